// File: design/netl_pkg.sv
// Package: shared constants and payload types for the nearest entry table lookup.
package netl_pkg;

    localparam int TABLE_ROWS_DEF = 1024;
    localparam int KEY_WORDS_DEF  = 6;
    localparam int JOINTS_DEF     = 7;
    localparam int QUERY_FIELDS   = 6;

    localparam int WORD_W    = 32;
    localparam int ROW_IDX_W = 10;
    localparam int COL_IDX_W = 5;
    localparam int SLOT_W    = 4;
    localparam int CFG_W     = 11;

    // 1e6 in Q32.32
    localparam logic [63:0] DIST_LIMIT = 64'd1000000 << 32;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [0:0] REG_ROWS_IN_USE = 1'b0;

    typedef struct packed {
        logic                        action;
        logic [ROW_IDX_W-1:0]        row_index;
        logic [COL_IDX_W-1:0]        column_index;
        logic signed [WORD_W-1:0]    load_word;
        logic signed [WORD_W-1:0]    pos_x;
        logic signed [WORD_W-1:0]    pos_y;
        logic signed [WORD_W-1:0]    pos_z;
        logic signed [WORD_W-1:0]    vel_x;
        logic signed [WORD_W-1:0]    vel_y;
        logic signed [WORD_W-1:0]    vel_z;
    } in_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0]    payload_word;
        logic [SLOT_W-1:0]           payload_slot;
        logic [ROW_IDX_W-1:0]        best_row;
        logic                        last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT,
        ST_WAIT
    } state_t;

endpackage

// File: design/nearest_entry_table_lookup_top.sv
// Top level: nearest entry table lookup with row memories and scan sequencer.
// Sequence: a load is accepted while idle. A query is accepted while idle, then reads
// one key row per cycle for min(rows_in_use, TABLE_ROWS) rows, makes an end-of-scan check,
// drains the distance pipeline and reads one payload word for each payload beat.
// A new query or load is not accepted until the last payload beat of the current query
// is taken; each payload beat waits on m_ready. Loads are accepted one per cycle while idle.
// Reset clears control state and sets rows_in_use to 1024; tables are not cleared.
module nearest_entry_table_lookup_top #(
    parameter int TABLE_ROWS = netl_pkg::TABLE_ROWS_DEF,
    parameter int KEY_WORDS  = netl_pkg::KEY_WORDS_DEF,
    parameter int JOINTS     = netl_pkg::JOINTS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  netl_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output netl_pkg::out_item_t  m_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int PAY_WORDS = 2 * JOINTS + 1;
    localparam int ROW_W     = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
    localparam int CNT_W     = $clog2(TABLE_ROWS + 1);
    localparam int PSLOT_W   = (PAY_WORDS > 1) ? $clog2(PAY_WORDS) : 1;
    localparam int KSEL_W    = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
    localparam int PAY_AW    = $clog2(TABLE_ROWS * PAY_WORDS);

    // memories
    logic [KEY_WORDS-1:0][31:0] key_mem [TABLE_ROWS];
    logic [31:0]                pay_mem [TABLE_ROWS * PAY_WORDS];
    logic [KEY_WORDS-1:0][31:0] key_rd_reg;
    logic [31:0]                pay_rd_reg;

    logic [netl_pkg::CFG_W-1:0] rows_in_use_reg;
    netl_pkg::state_t           state_reg, state_next;
    logic [CNT_W-1:0]           scan_cnt_reg, scan_cnt_next;
    logic [CNT_W-1:0]           scan_len_reg, scan_len_next;
    logic [ROW_W-1:0]           res_row_reg, res_row_next;
    logic [ROW_W-1:0]           best_row_reg, best_row_next;
    logic [63:0]                best_reg, best_next;
    logic [PSLOT_W-1:0]         slot_reg, slot_next;
    logic [KEY_WORDS-1:0][31:0] qkey_reg;
    logic                       rd_en;
    logic                       pay_rd;
    logic                       out_vld_reg, out_vld_next;
    logic                       dist_valid;
    logic [63:0]                row_dist;
    logic                       pend_reg, pend_next;
    logic                       load_ok;
    logic                       s_acc;
    logic [PAY_AW-1:0]          pay_wr_addr;
    logic [PAY_AW-1:0]          pay_rd_addr;

    assign pready = 1'b1;
    assign prdata = 32'(rows_in_use_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_in_use_reg <= netl_pkg::CFG_W'(1024);
        end else if (psel && penable && pwrite
                     && paddr[2] == netl_pkg::REG_ROWS_IN_USE) begin
            rows_in_use_reg <= pwdata[netl_pkg::CFG_W-1:0];
        end
    end

    assign s_acc   = s_valid && s_ready;
    assign load_ok = (32'(s_data.row_index) < 32'(TABLE_ROWS))
                     && (32'(s_data.column_index) < 32'(KEY_WORDS + PAY_WORDS));

    assign pay_wr_addr = PAY_AW'(32'(s_data.row_index) * PAY_WORDS
                                 + 32'(s_data.column_index) - KEY_WORDS);
    assign pay_rd_addr = PAY_AW'(32'(best_row_reg) * PAY_WORDS + 32'(slot_next));

    always_ff @(posedge aclk) begin
        if (s_acc && s_data.action == netl_pkg::ACT_LOAD && load_ok) begin
            if (32'(s_data.column_index) < 32'(KEY_WORDS)) begin
                key_mem[ROW_W'(s_data.row_index)][KSEL_W'(s_data.column_index)]
                    <= s_data.load_word;
            end else begin
                pay_mem[pay_wr_addr] <= s_data.load_word;
            end
        end
        if (rd_en) begin
            key_rd_reg <= key_mem[ROW_W'(scan_cnt_reg)];
        end
        if (pay_rd) begin
            pay_rd_reg <= pay_mem[pay_rd_addr];
        end
        if (s_acc && s_data.action == netl_pkg::ACT_QUERY) begin
            for (int j = 0; j < KEY_WORDS; j++) begin
                case (j)
                    0:       qkey_reg[j] <= s_data.pos_x;
                    1:       qkey_reg[j] <= s_data.pos_y;
                    2:       qkey_reg[j] <= s_data.pos_z;
                    3:       qkey_reg[j] <= s_data.vel_x;
                    4:       qkey_reg[j] <= s_data.vel_y;
                    5:       qkey_reg[j] <= s_data.vel_z;
                    default: qkey_reg[j] <= '0;
                endcase
            end
        end
    end

    logic key_vld_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) key_vld_reg <= 1'b0;
        else          key_vld_reg <= rd_en;
    end

    netl_dist #(.KEY_WORDS(KEY_WORDS)) u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (key_vld_reg),
        .row_key   (key_rd_reg),
        .query_key (qkey_reg),
        .out_valid (dist_valid),
        .out_dist  (row_dist)
    );

    always_comb begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        scan_len_next = scan_len_reg;
        res_row_next  = res_row_reg;
        best_row_next = best_row_reg;
        best_next     = best_reg;
        slot_next     = slot_reg;
        out_vld_next  = out_vld_reg;
        pend_next     = pend_reg;
        rd_en         = 1'b0;
        pay_rd        = 1'b0;
        s_ready       = 1'b0;

        // compare each distance as it leaves the pipeline
        if (dist_valid) begin
            if (row_dist < best_reg) begin
                best_next     = row_dist;
                best_row_next = res_row_reg;
            end
            res_row_next = res_row_reg + 1'b1;
        end

        case (state_reg)
            netl_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && s_data.action == netl_pkg::ACT_QUERY) begin
                    scan_cnt_next = '0;
                    scan_len_next = (32'(rows_in_use_reg) > 32'(TABLE_ROWS))
                                    ? CNT_W'(TABLE_ROWS) : CNT_W'(rows_in_use_reg);
                    res_row_next  = '0;
                    best_row_next = '0;
                    best_next     = netl_pkg::DIST_LIMIT;
                    state_next    = netl_pkg::ST_SCAN;
                end
            end
            netl_pkg::ST_SCAN: begin
                if (scan_cnt_reg == scan_len_reg) begin
                    state_next    = netl_pkg::ST_DRAIN;
                    scan_cnt_next = '0;
                end else begin
                    rd_en         = 1'b1;
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
            end
            netl_pkg::ST_DRAIN: begin
                // let the distance pipeline empty
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == CNT_W'(5)) begin
                    slot_next  = '0;
                    pay_rd     = 1'b1;
                    pend_next  = 1'b1;
                    state_next = netl_pkg::ST_EMIT;
                end
            end
            netl_pkg::ST_EMIT: begin
                if (pend_reg) begin
                    out_vld_next = 1'b1;
                    pend_next    = 1'b0;
                end else if (m_ready && out_vld_reg) begin
                    out_vld_next = 1'b0;
                    if (slot_reg == PSLOT_W'(PAY_WORDS - 1)) begin
                        state_next = netl_pkg::ST_IDLE;
                    end else begin
                        slot_next = slot_reg + 1'b1;
                        pay_rd    = 1'b1;
                        pend_next = 1'b1;
                    end
                end
            end
            default: state_next = netl_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= netl_pkg::ST_IDLE;
            out_vld_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
            pend_reg    <= pend_next;
        end
        scan_cnt_reg <= scan_cnt_next;
        scan_len_reg <= scan_len_next;
        res_row_reg  <= res_row_next;
        best_row_reg <= best_row_next;
        best_reg     <= best_next;
        slot_reg     <= slot_next;
    end

    assign m_valid              = out_vld_reg;
    assign m_data.payload_word  = pay_rd_reg;
    assign m_data.payload_slot  = netl_pkg::SLOT_W'(slot_reg);
    assign m_data.best_row      = netl_pkg::ROW_IDX_W'(best_row_reg);
    assign m_data.last          = (slot_reg == PSLOT_W'(PAY_WORDS - 1));

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != netl_pkg::ST_IDLE |-> !s_ready)
        else $error("input accepted while busy");
    a_best_below_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == netl_pkg::ST_EMIT |-> best_reg <= netl_pkg::DIST_LIMIT)
        else $error("best distance above limit");
    a_out_only_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> state_reg == netl_pkg::ST_EMIT)
        else $error("output valid outside emit");

endmodule

// File: design/netl_dist.sv
// Distance pipeline: squared Euclidean distance of one key row, saturating sum.
module netl_dist #(
    parameter int KEY_WORDS = netl_pkg::KEY_WORDS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   in_valid,
    input  logic [KEY_WORDS-1:0][netl_pkg::WORD_W-1:0] row_key,
    input  logic [KEY_WORDS-1:0][netl_pkg::WORD_W-1:0] query_key,
    output logic                                   out_valid,
    output logic [63:0]                            out_dist
);

    logic [KEY_WORDS-1:0][32:0] mag_reg;
    logic [KEY_WORDS-1:0][63:0] sq_reg;
    logic [63:0]                sum;
    logic [64:0]                acc;
    logic                       v1_reg, v2_reg, v3_reg;
    logic [63:0]                dist_reg;

    always_ff @(posedge aclk) begin
        for (int j = 0; j < KEY_WORDS; j++) begin
            logic signed [32:0] d;
            d = $signed({query_key[j][31], query_key[j]})
                - $signed({row_key[j][31], row_key[j]});
            mag_reg[j] <= d[32] ? 33'(-d) : 33'(d);
        end
        // one 33x33 square per lane
        for (int j = 0; j < KEY_WORDS; j++) begin
            sq_reg[j] <= 64'(mag_reg[j] * mag_reg[j]);
        end
        dist_reg <= sum;
    end

    // saturating sum over the lanes
    always_comb begin
        sum = '0;
        for (int j = 0; j < KEY_WORDS; j++) begin
            acc = {1'b0, sum} + {1'b0, sq_reg[j]};
            sum = acc[64] ? '1 : acc[63:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_dist  = dist_reg;

endmodule
